// ===== src/cl3d_pkg.sv =====
`default_nettype none

package cl3d_pkg;

    // multiplier digit width, one digit of the second operand per cycle
    localparam int MUL_DIGIT = 16;

    // fraction shifts of the gain products
    localparam int LG_SHIFT   = 30;
    localparam int GAIN_SHIFT = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 40;
    localparam int WARM_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int POINT_W    = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEED_P        = 3'd0,
        CFG_SEED_Q        = 3'd1,
        CFG_SEED_R        = 3'd2,
        CFG_LOGISTIC_GAIN = 3'd3,
        CFG_CROSS_GAIN_A  = 3'd4,
        CFG_CROSS_GAIN_B  = 3'd5,
        CFG_WARMUP_STEPS  = 3'd6,
        CFG_OUTPUT_SCALE  = 3'd7
    } t_cfg_idx;

    // one product each: the fifteen of the map step, then the output scale
    typedef enum logic [4:0] {
        OP_SQ_P  = 5'd0,
        OP_SQ_Q  = 5'd1,
        OP_SQ_R  = 5'd2,
        OP_LG_P  = 5'd3,
        OP_K_P   = 5'd4,
        OP_CA_P  = 5'd5,
        OP_CB_P  = 5'd6,
        OP_LG_Q  = 5'd7,
        OP_K_Q   = 5'd8,
        OP_CA_Q  = 5'd9,
        OP_CB_Q  = 5'd10,
        OP_LG_R  = 5'd11,
        OP_K_R   = 5'd12,
        OP_CA_R  = 5'd13,
        OP_CB_R  = 5'd14,
        OP_SCALE = 5'd15
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_WAIT  = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

endpackage

`default_nettype wire

// ===== src/cl3d_mul.sv =====
`default_nettype none

module cl3d_mul #(
    parameter int W = 32,
    localparam int NCH = (W + cl3d_pkg::MUL_DIGIT - 1) / cl3d_pkg::MUL_DIGIT,
    localparam int BW  = NCH * cl3d_pkg::MUL_DIGIT,
    localparam int PW  = W + BW
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [W-1:0]  i_a,
    input  wire logic [W-1:0]  i_b,
    output logic               o_done,
    output logic [PW-1:0]      o_prod
);
    import cl3d_pkg::*;

    localparam int CW = $clog2(NCH + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_a;
    logic [BW-1:0] r_b;
    logic [PW-1:0] r_acc;
    logic [W+MUL_DIGIT-1:0] w_part;

    // top digit first: acc = acc * 2^16 + a * digit
    assign w_part = r_a * r_b[BW-1 -: MUL_DIGIT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NCH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= BW'(i_b);
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= (r_acc << MUL_DIGIT) + PW'(w_part);
            r_b   <= r_b << MUL_DIGIT;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

// ===== src/coupled_logistic_3d_chaotic_byte_gen.sv =====
`default_nettype none

// channel  | direction | handshake                | payload
// ---------+-----------+--------------------------+-------------------------------------
// cfg      | in        | i_cfg_valid/o_cfg_ready  | i_cfg_index, i_cfg_data
// s (req)  | in        | i_s_tvalid/o_s_tready    | i_s_tdata: reseed [0]
// m (res)  | out       | o_m_tvalid/i_m_tready    | o_m_tdata: random_byte, point_value
//
// One map step is 15 products on the shared multiplier, which takes the second operand in NCH
// digits (NCH = ceil(max(FRAC_BITS,32)/16), 2 at FRAC_BITS=32); the byte needs one more product.
// A reseed request runs the configured warm-up steps before the step that forms the result;
// a plain request runs a single step.
// Synchronous active-low reset clears the map state to zero and loads register defaults.
// A new request is taken once the previous result has moved to the output register.

module coupled_logistic_3d_chaotic_byte_gen #(
    parameter int FRAC_BITS = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire cl3d_pkg::t_cfg_idx              i_cfg_index,
    input  wire logic [cl3d_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [cl3d_pkg::S_DATA_W-1:0]   i_s_tdata,  // [0] reseed
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [cl3d_pkg::M_DATA_W-1:0]        o_m_tdata   // [7:0] random_byte, [39:8] point_value
);
    import cl3d_pkg::*;

    localparam int FB    = FRAC_BITS;
    localparam int OW    = (FB > 32) ? FB : 32;
    localparam int NCH   = (OW + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int PW    = OW + NCH * MUL_DIGIT;
    localparam int SH_UP = (FB >= 32) ? FB - 32 : 0;
    localparam int SH_DN = (FB >= 32) ? 0 : 32 - FB;

    // configuration
    logic [31:0]       r_seed_p, r_seed_q, r_seed_r;
    logic [31:0]       r_gain_l, r_gain_a, r_gain_b, r_scale;
    logic [WARM_W-1:0] r_warmup;

    // control and map state
    t_state            r_state;
    t_op               r_op;
    logic [WARM_W-1:0] r_warm;
    logic [FB-1:0]     r_p, r_q, r_r;
    logic              r_out_valid;

    // step scratch
    logic [FB-1:0]     r_pp, r_qq, r_rr, r_tp, r_tq, r_tr, r_k;
    logic [FB-1:0]     r_np, r_nq, r_nr;
    logic [BYTE_W-1:0] r_byte;
    logic [M_DATA_W-1:0] r_out_data;

    logic              w_s_acc;
    logic              w_out_free;
    logic              w_mul_start;
    logic              w_mul_done;
    logic [OW-1:0]     w_a, w_b;
    logic [PW-1:0]     w_prod;
    logic [FB-1:0]     w_res_f, w_res_l, w_res_g, w_t1;
    logic              w_lo_nz;
    logic [POINT_W-1:0] w_point;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign w_s_acc     = i_s_tvalid && o_s_tready;
    assign w_out_free  = !r_out_valid || i_m_tready;
    assign w_mul_start = (r_state == S_ISSUE);

    always_comb begin
        w_a = '0;
        w_b = '0;
        unique case (r_op)
            OP_SQ_P:  begin w_a = OW'(r_p);      w_b = OW'(r_p);   end
            OP_SQ_Q:  begin w_a = OW'(r_q);      w_b = OW'(r_q);   end
            OP_SQ_R:  begin w_a = OW'(r_r);      w_b = OW'(r_r);   end
            OP_LG_P:  begin w_a = OW'(r_gain_l); w_b = OW'(r_tp);  end
            OP_K_P:   begin w_a = OW'(r_qq);     w_b = OW'(r_p);   end
            OP_CA_P:  begin w_a = OW'(r_gain_a); w_b = OW'(r_k);   end
            OP_CB_P:  begin w_a = OW'(r_gain_b); w_b = OW'(r_rr);  end
            OP_LG_Q:  begin w_a = OW'(r_gain_l); w_b = OW'(r_tq);  end
            OP_K_Q:   begin w_a = OW'(r_rr);     w_b = OW'(r_q);   end
            OP_CA_Q:  begin w_a = OW'(r_gain_a); w_b = OW'(r_k);   end
            OP_CB_Q:  begin w_a = OW'(r_gain_b); w_b = OW'(r_pp);  end
            OP_LG_R:  begin w_a = OW'(r_gain_l); w_b = OW'(r_tr);  end
            OP_K_R:   begin w_a = OW'(r_pp);     w_b = OW'(r_r);   end
            OP_CA_R:  begin w_a = OW'(r_gain_a); w_b = OW'(r_k);   end
            OP_CB_R:  begin w_a = OW'(r_gain_b); w_b = OW'(r_qq);  end
            OP_SCALE: begin w_a = OW'(r_p);      w_b = OW'(r_scale); end
            default:  begin w_a = '0;            w_b = '0;         end
        endcase
    end

    cl3d_mul #(
        .W (OW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    assign w_res_f = w_prod[FB +: FB];
    assign w_res_l = w_prod[LG_SHIFT +: FB];
    assign w_res_g = w_prod[GAIN_SHIFT +: FB];
    assign w_lo_nz = |w_prod[FB-1:0];
    // x*(1-x) = x - ceil(x*x)
    assign w_t1    = w_a[FB-1:0] - w_res_f - FB'(w_lo_nz);
    assign w_point = POINT_W'((OW'(r_p) >> SH_UP) << SH_DN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_p <= 32'd2147483648;
            r_seed_q <= 32'd1717986918;
            r_seed_r <= 32'd1288490189;
            r_gain_l <= 32'd3972844749;
            r_gain_a <= 32'd64424509;
            r_gain_b <= 32'd51539608;
            r_warmup <= 16'd1000;
            r_scale  <= 32'd1000000;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SEED_P:        r_seed_p <= i_cfg_data;
                CFG_SEED_Q:        r_seed_q <= i_cfg_data;
                CFG_SEED_R:        r_seed_r <= i_cfg_data;
                CFG_LOGISTIC_GAIN: r_gain_l <= i_cfg_data;
                CFG_CROSS_GAIN_A:  r_gain_a <= i_cfg_data;
                CFG_CROSS_GAIN_B:  r_gain_b <= i_cfg_data;
                CFG_WARMUP_STEPS:  r_warmup <= i_cfg_data[WARM_W-1:0];
                CFG_OUTPUT_SCALE:  r_scale  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_SQ_P;
            r_warm      <= '0;
            r_p         <= '0;
            r_q         <= '0;
            r_r         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_m_tvalid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_s_acc) begin
                        if (i_s_tdata[0]) begin
                            r_p    <= FB'((OW'(r_seed_p) << SH_UP) >> SH_DN);
                            r_q    <= FB'((OW'(r_seed_q) << SH_UP) >> SH_DN);
                            r_r    <= FB'((OW'(r_seed_r) << SH_UP) >> SH_DN);
                            r_warm <= r_warmup;
                        end
                        r_op    <= OP_SQ_P;
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_mul_done) begin
                        if (r_op == OP_CB_R) begin
                            r_state <= S_ISSUE;
                            r_p     <= r_np;
                            r_q     <= r_nq;
                            r_r     <= r_nr + w_res_g;
                            if (r_warm != '0) begin
                                r_warm <= r_warm - WARM_W'(1);
                                r_op   <= OP_SQ_P;
                            end else begin
                                r_op <= OP_SCALE;
                            end
                        end else if (r_op == OP_SCALE) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_ISSUE;
                            r_op    <= t_op'(r_op + 5'd1);
                        end
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WAIT && w_mul_done) begin
            unique case (r_op)
                OP_SQ_P:  begin r_pp <= w_res_f; r_tp <= w_t1; end
                OP_SQ_Q:  begin r_qq <= w_res_f; r_tq <= w_t1; end
                OP_SQ_R:  begin r_rr <= w_res_f; r_tr <= w_t1; end
                OP_LG_P:  r_np <= w_res_l;
                OP_LG_Q:  r_nq <= w_res_l;
                OP_LG_R:  r_nr <= w_res_l;
                OP_K_P, OP_K_Q, OP_K_R: r_k <= w_res_f;
                OP_CA_P, OP_CB_P: r_np <= r_np + w_res_g;
                OP_CA_Q, OP_CB_Q: r_nq <= r_nq + w_res_g;
                OP_CA_R:  r_nr <= r_nr + w_res_g;
                OP_CB_R:  ;
                OP_SCALE: r_byte <= w_res_f[BYTE_W-1:0];
                default: ;
            endcase
        end
        if (r_state == S_OUT && w_out_free) begin
            r_out_data <= {w_point, r_byte};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> (r_state == S_ISSUE && r_op == OP_SQ_P))
        else $error("request did not start a step at the first product");

    a_issue_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ISSUE) |=> (r_state == S_WAIT))
        else $error("product issued without waiting for it");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == S_WAIT))
        else $error("multiplier finished outside the wait state");

    a_scale_after_warm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT && r_op == OP_SCALE) |-> (r_warm == '0))
        else $error("byte formed while warm-up steps remain");

endmodule

`default_nettype wire

// ===== dv/cl3d_stream_checker.sv =====
`timescale 1ns / 100ps

module cl3d_stream_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    input  wire logic                            i_cfg_ready,
    input  wire cl3d_pkg::t_cfg_idx              i_cfg_index,
    input  wire logic [cl3d_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_s_tvalid,
    input  wire logic                            i_s_tready,
    input  wire logic [cl3d_pkg::S_DATA_W-1:0]   i_s_tdata,
    input  wire logic                            i_m_tvalid,
    input  wire logic                            i_m_tready,
    input  wire logic [cl3d_pkg::M_DATA_W-1:0]   i_m_tdata,
    output int                                   o_fail_count,
    output int                                   o_pending
);
    import cl3d_pkg::*;

    localparam int FRAC = 32;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic [POINT_W-1:0] point;
    } t_draw;

    t_draw draws_due[$];
    int    mismatches = 0;

    logic [31:0]     seed_p, seed_q, seed_r;
    logic [31:0]     gain_lg, gain_ca, gain_cb, out_scale;
    logic [WARM_W-1:0] warm_steps;
    logic [31:0]     p_frac, q_frac, r_frac;

    // (a*b) >> sh, low 64 bits of the exact product
    function automatic logic [63:0] mul_trunc(input logic [63:0] a, input logic [63:0] b,
                                              input int unsigned sh);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        prod = prod >> sh;
        return prod[63:0];
    endfunction

    function automatic logic [31:0] coord_next(input logic [31:0] x, input logic [31:0] y,
                                               input logic [31:0] z);
        logic [63:0] x64, t1, a, yy, b, zz, c, sum;
        x64 = {32'd0, x};
        t1  = mul_trunc(x64, 64'h1_0000_0000 - x64, FRAC);
        a   = mul_trunc({32'd0, gain_lg}, t1, LG_SHIFT);
        yy  = mul_trunc({32'd0, y}, {32'd0, y}, FRAC);
        b   = mul_trunc({32'd0, gain_ca}, mul_trunc(yy, x64, FRAC), GAIN_SHIFT);
        zz  = mul_trunc({32'd0, z}, {32'd0, z}, FRAC);
        c   = mul_trunc({32'd0, gain_cb}, zz, GAIN_SHIFT);
        sum = a + b + c;
        return sum[31:0];
    endfunction

    function automatic void advance_map();
        logic [31:0] p, q, r;
        p = p_frac;
        q = q_frac;
        r = r_frac;
        p_frac = coord_next(p, q, r);
        q_frac = coord_next(q, r, p);
        r_frac = coord_next(r, p, q);
    endfunction

    always @(posedge i_clk) begin : watch
        t_draw       got, want;
        logic [63:0] scaled;
        if (!i_rst_n) begin
            seed_p     = 32'd2147483648;
            seed_q     = 32'd1717986918;
            seed_r     = 32'd1288490189;
            gain_lg    = 32'd3972844749;
            gain_ca    = 32'd64424509;
            gain_cb    = 32'd51539608;
            warm_steps = 16'd1000;
            out_scale  = 32'd1000000;
            p_frac     = '0;
            q_frac     = '0;
            r_frac     = '0;
            draws_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SEED_P:        seed_p     = i_cfg_data;
                    CFG_SEED_Q:        seed_q     = i_cfg_data;
                    CFG_SEED_R:        seed_r     = i_cfg_data;
                    CFG_LOGISTIC_GAIN: gain_lg    = i_cfg_data;
                    CFG_CROSS_GAIN_A:  gain_ca    = i_cfg_data;
                    CFG_CROSS_GAIN_B:  gain_cb    = i_cfg_data;
                    CFG_WARMUP_STEPS:  warm_steps = i_cfg_data[WARM_W-1:0];
                    CFG_OUTPUT_SCALE:  out_scale  = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_m_tvalid && i_m_tready) begin
                got.out_byte = i_m_tdata[BYTE_W-1:0];
                got.point    = i_m_tdata[BYTE_W +: POINT_W];
                if (draws_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: byte %0d point %h",
                                 got.out_byte, got.point);
                end else begin
                    want = draws_due.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result mismatch: expected byte %0d point %h, ",
                                      "got byte %0d point %h"},
                                     want.out_byte, want.point, got.out_byte, got.point);
                    end
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tdata[0]) begin
                    p_frac = seed_p;
                    q_frac = seed_q;
                    r_frac = seed_r;
                    for (int n = 0; n < int'(warm_steps); n++)
                        advance_map();
                end
                advance_map();
                scaled        = mul_trunc({32'd0, p_frac}, {32'd0, out_scale}, FRAC);
                want.out_byte = scaled[BYTE_W-1:0];
                want.point    = p_frac;
                draws_due.insert(draws_due.size(), want);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= draws_due.size();
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import cl3d_pkg::*;

    // quietest stretch: a reseed with the default 1000-step warm-up
    localparam int WATCHDOG_LIMIT = 250000;
    localparam int PRESSURE_HOLD  = 600;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    t_cfg_idx              i_cfg_index = CFG_SEED_P;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [S_DATA_W-1:0]   i_s_tdata   = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   o_m_tdata;

    int fail_count;
    int pending;

    bit steady        = 1'b0;
    int hold_requests = 0;

    logic [CFG_DATA_W-1:0] next_regs [8];

    always #6 i_clk = ~i_clk;

    coupled_logistic_3d_chaotic_byte_gen DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    cl3d_stream_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return $urandom_range(1, 3);
        if (roll < 92)
            return $urandom_range(4, 20);
        return $urandom_range(40, 200);
    endfunction

    function automatic int sender_gap();
        if (steady || $urandom_range(0, 2) != 0)
            return 0;
        return pick_gap();
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            i_cfg_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic load_registers(input bit every_reg);
        int first;
        int k;
        first = $urandom_range(0, 7);
        for (int n = 0; n < 8; n++) begin
            k = (first + n) % 8;
            if (every_reg || $urandom_range(0, 1) == 1)
                write_reg(t_cfg_idx'(k[CFG_IDX_W-1:0]), next_regs[k]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input logic [31:0] sp, input logic [31:0] sq, input logic [31:0] sr,
                            input logic [31:0] lg, input logic [31:0] ca, input logic [31:0] cb,
                            input logic [15:0] wu, input logic [31:0] sc);
        next_regs[CFG_SEED_P]        = sp;
        next_regs[CFG_SEED_Q]        = sq;
        next_regs[CFG_SEED_R]        = sr;
        next_regs[CFG_LOGISTIC_GAIN] = lg;
        next_regs[CFG_CROSS_GAIN_A]  = ca;
        next_regs[CFG_CROSS_GAIN_B]  = cb;
        next_regs[CFG_WARMUP_STEPS]  = {16'd0, wu};
        next_regs[CFG_OUTPUT_SCALE]  = sc;
    endtask

    function automatic logic [31:0] pick_seed();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return 32'h0000_0000;
        if (roll == 1)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    task automatic randomise_settings();
        int          roll;
        logic [31:0] lg, ca, cb, sc;
        logic [15:0] wu;
        roll = $urandom_range(0, 19);
        if (roll < 14)
            lg = $urandom_range(32'd3790323302, 32'd4090987028);
        else if (roll < 17)
            lg = $urandom;
        else
            lg = (roll == 17) ? 32'h0000_0000 : 32'hFFFF_FFFF;
        ca = ($urandom_range(0, 9) < 7) ? $urandom_range(32'd42949673, 32'd85899346) : $urandom;
        cb = ($urandom_range(0, 9) < 7) ? $urandom_range(32'd42949673, 32'd60129542) : $urandom;
        roll = $urandom_range(0, 19);
        if (roll < 16)
            wu = $urandom_range(0, 8);
        else if (roll < 19)
            wu = $urandom_range(9, 40);
        else
            wu = $urandom_range(100, 200);
        roll = $urandom_range(0, 9);
        if (roll < 4)
            sc = $urandom;
        else if (roll < 7)
            sc = $urandom_range(1, 1000000);
        else if (roll == 7)
            sc = 32'd1;
        else if (roll == 8)
            sc = 32'd0;
        else
            sc = 32'hFFFF_FFFF;
        set_regs(pick_seed(), pick_seed(), pick_seed(), lg, ca, cb, wu, sc);
    endtask

    task automatic send_request(input bit reseed);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(S_DATA_W-1){1'b0}}, reseed};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // result side: random stalls, plus long hold-offs on request
    initial begin : sink
        int stall;
        int holds_done;
        stall      = 0;
        holds_done = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (holds_done != hold_requests) begin
                holds_done++;
                i_m_tready <= 1'b0;
                repeat (PRESSURE_HOLD) @(posedge i_clk);
                stall = 0;
            end
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                stall--;
            end else if (steady || $urandom_range(0, 3) != 0) begin
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b0;
                stall = pick_gap() - 1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("coupled_logistic_3d_chaotic_byte_gen test failed");
        $finish;
    end

    initial begin : stimulus
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // map still at zero before any reseed, then reseed with reset defaults
        repeat (3) send_request(1'b0);
        send_request(1'b1);
        repeat (2) send_request(1'b0);
        drain();

        // zero warm-up and zero scale
        set_regs(32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'd3972844749,
                 32'd64424509, 32'd51539608, 16'd0, 32'd0);
        load_registers(1'b1);
        send_request(1'b1);
        repeat (2) send_request(1'b0);
        drain();

        // everything but the warm-up at full scale, sum wraps
        set_regs('1, '1, '1, '1, '1, '1, 16'd1, '1);
        load_registers(1'b1);
        send_request(1'b1);
        send_request(1'b0);
        drain();

        // seeds and gains all zero
        set_regs('0, '0, '0, '0, '0, '0, 16'd2, 32'd1);
        load_registers(1'b1);
        send_request(1'b1);
        send_request(1'b0);
        drain();

        set_regs(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'd3900000000,
                 32'd80000000, 32'd45000000, 16'd3, 32'd255);
        load_registers(1'b1);
        send_request(1'b1);
        send_request(1'b0);
        drain();

        // longest warm-up loaded; no reseed while it is in force
        write_reg(CFG_WARMUP_STEPS, 32'd65535);
        i_cfg_valid <= 1'b0;
        repeat (2) send_request(1'b0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            randomise_settings();
            load_registers(ph == 0);
            steady = (ph % 3 == 2);
            if (ph == 1) begin
                steady = 1'b1;
                hold_requests++;
            end
            send_request(1'b1);
            for (int n = 1; n < 62; n++)
                send_request($urandom_range(0, 19) == 0);
            drain();
        end

        repeat (80) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("coupled_logistic_3d_chaotic_byte_gen test passed");
        else
            $display("coupled_logistic_3d_chaotic_byte_gen test failed");
        $finish;
    end

endmodule
